// ----- rtl/grr_pkg.sv -----
// Shared types for the glyph row run rectangle block.
package grr_pkg;

  // One glyph row as it arrives.
  typedef struct packed {
    logic        [63:0] row_bits;
    logic        [6:0]  glyph_width;
    logic        [5:0]  row_index;
    logic        [6:0]  glyph_height;
    logic signed [7:0]  glyph_x_offset;
    logic signed [7:0]  glyph_y_offset;
    logic        [9:0]  pen_x;
    logic        [9:0]  pen_y;
  } row_item_t;

  // One run rectangle as it leaves.
  typedef struct packed {
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic        [6:0]  rect_width;
    logic               last_of_row;
  } rect_item_t;

  // Register indexes on the configuration port.
  localparam logic REG_BOLD_MODE   = 1'b0;
  localparam logic REG_FONT_ASCENT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } scan_state_t;

endpackage

// ----- rtl/glyph_row_run_rectangles.sv -----
// Glyph row to run rectangle converter, top level.
//
// Usage: a glyph row item enters on row/row_valid/row_stall. The row bits are
// loaded into a shift register and scanned one pixel column per cycle, while
// the scan is not paused, from column 0 upward. Each maximal run of lit pixels
// gives one rectangle item on rect/rect_valid/rect_stall, one pixel high, in
// column order; the last one of the row carries last_of_row. Empty rows, zero
// width and rows outside the glyph give no item.
// Sequence: a row is accepted, its columns are scanned serially (glyph_width
// clamped to MAX_GLYPH_WIDTH), the end-of-row column closes any open run and
// the held rectangle is flushed. Rows rejected at entry never leave idle.
// Only one row is in work at a time.
// Ordering: each rectangle is held until the next run ends (or the row ends)
// so the last one can be marked, and is then registered onto the output.
// Stall: the output register holds while rect_stall is high; the scan pauses
// only when it has a new rectangle and no free slot.
// Reset (rst, synchronous): clears bold_mode, font_ascent and all control
// state. Configuration is an APB-style port, registers at 0 and 4.
module glyph_row_run_rectangles
  import grr_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // row item channel
  input  row_item_t   row,
  input  logic        row_valid,
  output logic        row_stall,
  // rectangle item channel
  output rect_item_t  rect,
  output logic        rect_valid,
  input  logic        rect_stall,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // column counter holds 0..MAX_GLYPH_WIDTH
  localparam int CW = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam logic [6:0] MAX_W7 = 7'(MAX_GLYPH_WIDTH);

  // configuration registers
  logic       bold_mode;
  logic [7:0] font_ascent;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bold_mode   <= 1'b0;
      font_ascent <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_BOLD_MODE:   bold_mode   <= pwdata[0];
        REG_FONT_ASCENT: font_ascent <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_BOLD_MODE:   prdata = {31'd0, bold_mode};
      REG_FONT_ASCENT: prdata = {24'd0, font_ascent};
      default: ;
    endcase
  end

  // scan state
  scan_state_t state, state_next;
  logic [MAX_GLYPH_WIDTH-1:0] bits;     // pixel shift register, LSB is current column
  logic [CW-1:0]              col;
  logic [CW-1:0]              width_r;
  logic [11:0]                x_pos;    // left pixel of current column
  logic [11:0]                top_r;
  logic                       in_run;
  logic [11:0]                run_x;
  logic [6:0]                 run_len;
  logic                       pend_valid;
  rect_item_t                 pend;     // rectangle held back until the next one is known

  // entry decode
  logic [6:0]  width_clamp;
  logic        row_empty;
  logic [11:0] left_in;
  logic [11:0] top_in;

  always_comb begin
    width_clamp = (row.glyph_width > MAX_W7) ? MAX_W7 : row.glyph_width;
    row_empty   = (width_clamp == 7'd0) || ({1'b0, row.row_index} >= row.glyph_height);
    left_in     = {2'b00, row.pen_x} + {{4{row.glyph_x_offset[7]}}, row.glyph_x_offset};
    top_in      = {2'b00, row.pen_y} + {4'b0000, font_ascent}
                - ({{4{row.glyph_y_offset[7]}}, row.glyph_y_offset}
                   + {5'b00000, row.glyph_height})
                + {6'b000000, row.row_index};
  end

  // per-column decode
  logic out_free;
  logic lit;
  logic run_end;
  logic step;
  logic push;
  logic push_last;
  logic accept;
  logic scan_last;

  always_comb begin
    out_free  = !rect_valid || !rect_stall;
    lit       = (col < width_r) && bits[0];
    run_end   = in_run && !lit;
    scan_last = (col == width_r);
    accept    = row_valid && !row_stall;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && !row_empty) state_next = S_SCAN;
      S_SCAN: if (step && scan_last) state_next = S_DONE;
      S_DONE: if (!pend_valid || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    row_stall = 1'b1;
    step      = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state)
      S_IDLE: row_stall = 1'b0;
      S_SCAN: begin
        // pause only when a rectangle must leave and the slot is taken
        step = out_free || !(run_end && pend_valid);
        push = step && run_end && pend_valid;
      end
      S_DONE: begin
        push      = pend_valid && out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_run     <= 1'b0;
      pend_valid <= 1'b0;
      rect_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (push) begin
        rect_valid <= 1'b1;
      end else if (!rect_stall) begin
        rect_valid <= 1'b0;
      end

      if (state == S_SCAN && step) begin
        if (lit && !in_run) begin
          in_run <= 1'b1;
        end else if (run_end) begin
          in_run     <= 1'b0;
          pend_valid <= 1'b1;
        end
      end else if (state == S_DONE && push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      rect <= {pend.rect_x, pend.rect_y, pend.rect_width, push_last};
    end

    if (accept) begin
      bits    <= row.row_bits[MAX_GLYPH_WIDTH-1:0];
      col     <= '0;
      width_r <= width_clamp[CW-1:0];
      x_pos   <= left_in;
      top_r   <= top_in;
    end else if (state == S_SCAN && step) begin
      bits  <= bits >> 1;
      col   <= col + 1'b1;
      x_pos <= x_pos + 12'd1;
      if (lit && !in_run) begin
        run_x   <= x_pos;
        run_len <= 7'd1;
      end else if (lit) begin
        run_len <= run_len + 7'd1;
      end else if (run_end) begin
        pend.rect_x      <= run_x;
        pend.rect_y      <= top_r;
        pend.rect_width  <= run_len + {6'd0, bold_mode};
        pend.last_of_row <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // nothing may be held back once the row is finished
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held rectangle left behind at end of row");

  // a run is only open while scanning
  a_run_in_scan: assert property (@(posedge clk) disable iff (rst)
    in_run |-> (state == S_SCAN))
    else $error("open run outside the scan");

  // the scan never passes the end-of-row column
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (col <= width_r))
    else $error("column counter beyond row width");

  // a pushed rectangle appears on the output the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> rect_valid)
    else $error("pushed rectangle not presented");
`endif

endmodule

// ----- bench/glyph_row_run_rectangles_tb.sv -----
// Self-checking testbench for the glyph row run rectangle block.
module glyph_row_run_rectangles_tb;
  import grr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the run rectangles of each accepted row and checks what comes out.
  class rect_scoreboard;
    bit         bold;
    bit [7:0]   ascent;
    rect_item_t pending_rects[$];
    int         failures;

    function void report_failure(string what, rect_item_t want, rect_item_t got);
      failures++;
      if (failures <= 10) begin
        $display("%0t %s: want x=%0d y=%0d w=%0d last=%0b, got x=%0d y=%0d w=%0d last=%0b",
                 $realtime, what, want.rect_x, want.rect_y, want.rect_width,
                 want.last_of_row, got.rect_x, got.rect_y, got.rect_width,
                 got.last_of_row);
      end
    endfunction

    // Scan the row column by column, one rectangle per maximal run of lit pixels.
    function void note_row(row_item_t r);
      int         w;
      int         left;
      int         top;
      int         start;
      int         count;
      bit         lit;
      rect_item_t e;
      rect_item_t row_rects[$];
      w = (r.glyph_width > 7'd64) ? 64 : int'(r.glyph_width);
      if (w == 0 || r.row_index >= r.glyph_height) return;
      left = int'(r.pen_x) + int'($signed(r.glyph_x_offset));
      top  = int'(r.pen_y) + int'(ascent)
           - (int'($signed(r.glyph_y_offset)) + int'(r.glyph_height))
           + int'(r.row_index);
      start = -1;
      count = 0;
      // one column past the width closes a run that reaches the edge
      for (int col = 0; col <= w; col++) begin
        lit = (col < w) ? r.row_bits[col] : 1'b0;
        if (lit) begin
          if (start < 0) start = col;
        end else if (start >= 0) begin
          if (count < 32) begin
            e.rect_x      = 12'(left + start);
            e.rect_y      = 12'(top);
            e.rect_width  = 7'(col - start + int'(bold));
            e.last_of_row = 1'b0;
            row_rects.push_back(e);
            count++;
          end
          start = -1;
        end
      end
      foreach (row_rects[i]) begin
        e = row_rects[i];
        e.last_of_row = (i == row_rects.size() - 1);
        pending_rects.push_back(e);
      end
    endfunction

    function void check_rect(rect_item_t got);
      rect_item_t want;
      if (pending_rects.size() == 0) begin
        want = '0;
        report_failure("rectangle with none pending", want, got);
        return;
      end
      want = pending_rects.pop_front();
      if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y ||
          got.rect_width !== want.rect_width || got.last_of_row !== want.last_of_row) begin
        report_failure("rectangle mismatch", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  row_item_t   row = '0;
  logic        row_valid = 1'b0;
  logic        row_stall;
  rect_item_t  rect;
  logic        rect_valid;
  logic        rect_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rect_scoreboard sb = new();

  // When set, neither side idles between items.
  bit no_idle = 1'b0;
  // Long receiver hold-off request, in cycles; picked up by the receiver.
  int hold_req = 0;

  glyph_row_run_rectangles uut (
    .clk        (clk),
    .rst        (rst),
    .row        (row),
    .row_valid  (row_valid),
    .row_stall  (row_stall),
    .rect       (rect),
    .rect_valid (rect_valid),
    .rect_stall (rect_stall),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: after each accepted rectangle, stall for a random number of
  // cycles. A pending hold-off request overrides the draw with a long stall,
  // so the block backs up and has to stall its row input.
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rect_valid && !rect_stall) begin
        sb.check_rect(rect);
        wait_left = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (hold_req > 0) begin
        wait_left = hold_req;
        hold_req  = 0;
      end
      if (wait_left > 0) begin
        rect_stall <= 1'b1;
        wait_left--;
      end else begin
        rect_stall <= 1'b0;
      end
    end
  end

  function automatic row_item_t mk_row(logic [63:0] bits, int w, int ri, int h,
                                       int xo, int yo, int px, int py);
    row_item_t r;
    r.row_bits       = bits;
    r.glyph_width    = 7'(w);
    r.row_index      = 6'(ri);
    r.glyph_height   = 7'(h);
    r.glyph_x_offset = 8'(xo);
    r.glyph_y_offset = 8'(yo);
    r.pen_x          = 10'(px);
    r.pen_y          = 10'(py);
    return r;
  endfunction

  // Mostly well-formed rows with lit runs; now and then zero width, clamped
  // width or a row outside the glyph.
  function automatic row_item_t rand_row();
    row_item_t   r;
    logic [63:0] a;
    logic [63:0] b;
    int          ri;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       r.row_bits = a & b;                    // sparse
      1:       r.row_bits = a | b;                    // dense
      2:       r.row_bits = 64'h5555_5555_5555_5555 << $urandom_range(0, 1);
      3:       r.row_bits = '1;
      4:       r.row_bits = '0;
      5:       r.row_bits = a & b & {$urandom, $urandom};
      default: r.row_bits = a;
    endcase
    case ($urandom_range(0, 19))
      0:       r.glyph_width = 7'd0;
      1, 2:    r.glyph_width = 7'($urandom_range(65, 127));
      3, 4, 5: r.glyph_width = 7'($urandom_range(1, 8));
      default: r.glyph_width = 7'($urandom_range(1, 64));
    endcase
    ri = $urandom_range(0, 63);
    r.row_index = 6'(ri);
    case ($urandom_range(0, 9))
      0:       r.glyph_height = 7'($urandom_range(0, ri));      // row outside glyph
      1:       r.glyph_height = 7'($urandom_range(65, 127));
      default: r.glyph_height = 7'($urandom_range(ri + 1, 64));
    endcase
    r.glyph_x_offset = 8'($urandom);
    r.glyph_y_offset = 8'($urandom);
    r.pen_x          = 10'($urandom);
    r.pen_y          = 10'($urandom);
    return r;
  endfunction

  // Offer one row after a random gap and wait for it to be taken.
  task automatic send_row(input row_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      row_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row       <= it;
    row_valid <= 1'b1;
    @(posedge clk);
    while (row_stall) @(posedge clk);
    sb.note_row(it);
  endtask

  // Wait until every predicted rectangle is out, then let a full-width scan
  // of a row with no runs finish before touching the registers.
  task automatic drain();
    row_valid <= 1'b0;
    while (sb.pending_rects.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; upper data bits are junk the register drops.
  task automatic cfg_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BOLD_MODE) sb.bold = data[0];
    else                      sb.ascent = data[7:0];
    @(posedge clk);
  endtask

  // One configuration setting followed by a run of random rows.
  task automatic run_phase(input bit bold, input bit [7:0] ascent, input int n,
                           input bit pressure);
    drain();
    cfg_write(REG_BOLD_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(bold));
    cfg_write(REG_FONT_ASCENT, ($urandom & 32'hFFFF_FF00) | 32'(ascent));
    if (pressure) begin
      // receiver holds off while rows keep coming back to back
      no_idle  = 1'b1;
      hold_req = 400;
      repeat (24) send_row(rand_row());
    end
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_row(rand_row());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset register values.
    send_row(mk_row('1, 64, 0, 1, 0, 0, 0, 0));                         // one full-width run
    send_row(mk_row(64'h5555_5555_5555_5555, 64, 63, 64, -128, 127, 0, 0)); // 32 runs, low corner
    send_row(mk_row(64'hAAAA_AAAA_AAAA_AAAA, 64, 0, 127, 127, -128, 1023, 1023));
    send_row(mk_row(64'h8000_0000_0000_0001, 64, 5, 6, 3, -3, 100, 200)); // runs at both edges
    send_row(mk_row('1, 100, 1, 2, -5, 5, 512, 512));                   // width clamped
    send_row(mk_row(64'h5555_5555_5555_5555, 127, 2, 3, 10, 10, 0, 1023));
    send_row(mk_row(64'hFFFF_FFFF_FFFF_FF3C, 8, 3, 8, 0, 0, 50, 50));   // bits past width dropped
    send_row(mk_row('1, 0, 0, 1, 0, 0, 0, 0));                          // zero width
    send_row(mk_row('1, 64, 10, 10, 0, 0, 0, 0));                       // row outside glyph
    send_row(mk_row('1, 64, 63, 0, 0, 0, 0, 0));                        // zero height
    send_row(mk_row('0, 64, 0, 1, 0, 0, 0, 0));                         // empty row
    send_row(mk_row(64'h1, 1, 0, 1, -1, -1, 1, 1));                     // single pixel
    send_row(mk_row(64'h0123_4567_89AB_CDEF, 33, 40, 127, 7, 9, 300, 700)); // large height
    send_row(mk_row(64'h0F0F_F0F0_0F0F_F0F0, 64, 7, 16, -64, 64, 1000, 3));
    send_row(mk_row('1, 63, 4, 5, 1, 1, 2, 2));                         // run hits width
    send_row(mk_row(64'hFFFF_FFFF_FFFF_FFFE, 64, 0, 64, 0, -128, 0, 1023));

    // Random rows over several settings, extremes included.
    run_phase(1'b1, 8'd255, 70, 1'b0);
    run_phase(1'b0, 8'd255, 60, 1'b1);
    run_phase(1'b1, 8'd0, 70, 1'b0);
    run_phase(1'b0, 8'd0, 60, 1'b0);
    run_phase(1'($urandom), 8'($urandom), 60, 1'b0);
    run_phase(1'($urandom), 8'($urandom), 40, 1'b0);

    drain();
    sb.failures += sb.pending_rects.size();
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
